// File: src/smie_pkg.sv
// Package for the integer stack machine executor: op and status codes,
// microcode step addresses, control word type and the microcode ROM.
// No dependencies.
`default_nettype none

package smie_pkg;

   // Field widths fixed by the instruction format
   localparam int OP_W       = 3;
   localparam int DATA_W     = 32;
   localparam int ST_W       = 2;
   localparam int DIV_CNT_W  = 5;
   localparam int UPC_W      = 5;

   // Instruction codes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [ST_W-1:0] ST_DIVZERO   = 2'd3;

   // Stack count operations
   localparam logic [2:0] CNT_HOLD  = 3'd0;
   localparam logic [2:0] CNT_INC   = 3'd1;
   localparam logic [2:0] CNT_DEC   = 3'd2;
   localparam logic [2:0] CNT_DEC2  = 3'd3;
   localparam logic [2:0] CNT_CLEAR = 3'd4;

   // Stack read address select
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_TOP  = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   // Result register select
   localparam logic [1:0] RES_HOLD = 2'd0;
   localparam logic [1:0] RES_ALU  = 2'd1;
   localparam logic [1:0] RES_QUOT = 2'd2;

   // Stack write data select
   localparam logic WR_IMM = 1'b0;
   localparam logic WR_RES = 1'b1;

   // Jump conditions
   localparam logic [3:0] J_NEXT      = 4'd0;
   localparam logic [3:0] J_ALWAYS    = 4'd1;
   localparam logic [3:0] J_WAIT_ITEM = 4'd2;
   localparam logic [3:0] J_FULL      = 4'd3;
   localparam logic [3:0] J_EMPTY     = 4'd4;
   localparam logic [3:0] J_ONE       = 4'd5;
   localparam logic [3:0] J_IS_DIV    = 4'd6;
   localparam logic [3:0] J_RZERO     = 4'd7;
   localparam logic [3:0] J_DIVLOOP   = 4'd8;

   // Microcode step addresses
   localparam logic [UPC_W-1:0] S_IDLE  = 5'd0;
   localparam logic [UPC_W-1:0] S_PUSH0 = 5'd1;
   localparam logic [UPC_W-1:0] S_PUSH1 = 5'd2;
   localparam logic [UPC_W-1:0] S_POP0  = 5'd3;
   localparam logic [UPC_W-1:0] S_POP1  = 5'd4;
   localparam logic [UPC_W-1:0] S_BIN0  = 5'd5;
   localparam logic [UPC_W-1:0] S_BIN1  = 5'd6;
   localparam logic [UPC_W-1:0] S_BIN2  = 5'd7;
   localparam logic [UPC_W-1:0] S_BIN3  = 5'd8;
   localparam logic [UPC_W-1:0] S_BIN4  = 5'd9;
   localparam logic [UPC_W-1:0] S_ALU   = 5'd10;
   localparam logic [UPC_W-1:0] S_DIV0  = 5'd11;
   localparam logic [UPC_W-1:0] S_DIV1  = 5'd12;
   localparam logic [UPC_W-1:0] S_DIV2  = 5'd13;
   localparam logic [UPC_W-1:0] S_DIV3  = 5'd14;
   localparam logic [UPC_W-1:0] S_WRES  = 5'd15;
   localparam logic [UPC_W-1:0] S_OVF   = 5'd16;
   localparam logic [UPC_W-1:0] S_UNF   = 5'd17;
   localparam logic [UPC_W-1:0] S_UNF1  = 5'd18;
   localparam logic [UPC_W-1:0] S_DZ    = 5'd19;
   localparam logic [UPC_W-1:0] S_FIN0  = 5'd20;
   localparam logic [UPC_W-1:0] S_FIN1  = 5'd21;

   // One microcode control word
   typedef struct packed {
      logic [2:0]       cnt_op;
      logic [1:0]       rd_sel;
      logic             ld_right;
      logic             ld_left;
      logic [1:0]       res_sel;
      logic             div_init;
      logic             div_step;
      logic             wr_en;
      logic             wr_sel;
      logic             st_load;
      logic [ST_W-1:0]  st_value;
      logic             emit;
      logic [3:0]       jmp;
      logic [UPC_W-1:0] target;
   } ctrl_type;

   // Entry step for each instruction; unused codes go straight to the result
   function automatic logic [UPC_W-1:0] entry_step(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] s;
      case (op) inside
         OP_PUSH: s = S_PUSH0;
         OP_POP:  s = S_POP0;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: s = S_BIN0;
         default: s = S_FIN0;
      endcase
      return s;
   endfunction

   // Microcode ROM
   function automatic ctrl_type ucode(input logic [UPC_W-1:0] upc);
      ctrl_type w;
      w          = '0;
      w.cnt_op   = CNT_HOLD;
      w.rd_sel   = RD_NONE;
      w.res_sel  = RES_HOLD;
      w.st_value = ST_OK;
      w.jmp      = J_NEXT;
      w.target   = S_IDLE;
      case (upc)
         S_IDLE: begin
            w.jmp = J_WAIT_ITEM;
         end
         S_PUSH0: begin
            w.jmp    = J_FULL;
            w.target = S_OVF;
         end
         S_PUSH1: begin
            w.wr_en  = 1'b1;
            w.wr_sel = WR_IMM;
            w.cnt_op = CNT_INC;
            w.jmp    = J_ALWAYS;
            w.target = S_FIN0;
         end
         S_POP0: begin
            w.jmp    = J_EMPTY;
            w.target = S_UNF;
         end
         S_POP1: begin
            w.cnt_op = CNT_DEC;
            w.jmp    = J_ALWAYS;
            w.target = S_FIN0;
         end
         S_BIN0: begin
            w.jmp    = J_EMPTY;
            w.target = S_UNF;
         end
         S_BIN1: begin
            w.jmp    = J_ONE;
            w.target = S_UNF1;
         end
         S_BIN2: begin
            w.rd_sel = RD_TOP;
         end
         S_BIN3: begin
            w.ld_right = 1'b1;
            w.rd_sel   = RD_NEXT;
         end
         S_BIN4: begin
            w.ld_left = 1'b1;
            w.cnt_op  = CNT_DEC2;
            w.jmp     = J_IS_DIV;
            w.target  = S_DIV0;
         end
         S_ALU: begin
            w.res_sel = RES_ALU;
            w.jmp     = J_ALWAYS;
            w.target  = S_WRES;
         end
         S_DIV0: begin
            w.jmp    = J_RZERO;
            w.target = S_DZ;
         end
         S_DIV1: begin
            w.div_init = 1'b1;
         end
         S_DIV2: begin
            w.div_step = 1'b1;
            w.jmp      = J_DIVLOOP;
            w.target   = S_DIV2;
         end
         S_DIV3: begin
            w.res_sel = RES_QUOT;
         end
         S_WRES: begin
            w.wr_en  = 1'b1;
            w.wr_sel = WR_RES;
            w.cnt_op = CNT_INC;
            w.jmp    = J_ALWAYS;
            w.target = S_FIN0;
         end
         S_OVF: begin
            w.st_load  = 1'b1;
            w.st_value = ST_OVERFLOW;
            w.jmp      = J_ALWAYS;
            w.target   = S_FIN0;
         end
         S_UNF: begin
            w.st_load  = 1'b1;
            w.st_value = ST_UNDERFLOW;
            w.jmp      = J_ALWAYS;
            w.target   = S_FIN0;
         end
         S_UNF1: begin
            w.cnt_op   = CNT_CLEAR;
            w.st_load  = 1'b1;
            w.st_value = ST_UNDERFLOW;
            w.jmp      = J_ALWAYS;
            w.target   = S_FIN0;
         end
         S_DZ: begin
            w.st_load  = 1'b1;
            w.st_value = ST_DIVZERO;
         end
         S_FIN0: begin
            w.rd_sel = RD_TOP;
         end
         S_FIN1: begin
            w.emit   = 1'b1;
            w.jmp    = J_ALWAYS;
            w.target = S_IDLE;
         end
         default: begin
            w.jmp    = J_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/smie_if.sv
// Channel interfaces of the stack machine executor: instruction items in,
// result items out. Uses smie_pkg for field widths.
`default_nettype none

interface smie_req_if;
   logic                               valid;
   logic                               ready;
   logic        [smie_pkg::OP_W-1:0]   op;
   logic signed [smie_pkg::DATA_W-1:0] immediate;

   modport source (output valid, output op, output immediate, input ready);
   modport sink   (input valid, input op, input immediate, output ready);
endinterface

interface smie_rsp_if #(
   parameter int COUNT_W = 5
);
   logic                               valid;
   logic                               ready;
   logic signed [smie_pkg::DATA_W-1:0] top_value;
   logic        [COUNT_W-1:0]          depth;
   logic        [smie_pkg::ST_W-1:0]   status;

   modport source (output valid, output top_value, output depth, output status,
                   input ready);
   modport sink   (input valid, input top_value, input depth, input status,
                   output ready);
endinterface

`default_nettype wire

// File: src/stack_machine_int_exec.sv
// The divider loop yields one quotient bit a cycle. The next item is taken the cycle after
// the result is loaded; the result register lets it in while a result waits, and the next
// result holds at the last step until that one is taken. Synchronous active-high reset
// empties the stack; contents are kept. Uses smie_pkg, smie_if.
`default_nettype none

module stack_machine_int_exec #(
   parameter int STACK_DEPTH = 16
) (
   input  wire             clock,
   input  wire             reset,
   smie_req_if.sink        req_ch,
   smie_rsp_if.source      rsp_ch
);

   localparam int CountW = $clog2(STACK_DEPTH + 1);
   localparam int AddrW  = $clog2(STACK_DEPTH);
   localparam int DW     = smie_pkg::DATA_W;

   // Sequencer and datapath state
   logic [smie_pkg::UPC_W-1:0]     upc_ff, upc_in;
   logic [CountW-1:0]              count_ff, count_in;
   logic [smie_pkg::OP_W-1:0]      op_ff;
   logic [DW-1:0]                  imm_ff;
   logic [DW-1:0]                  right_ff, left_ff, res_ff, rd_data_ff;
   logic [DW-1:0]                  quo_ff, rem_ff, dvsr_ff;
   logic                           neg_q_ff;
   logic [smie_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [smie_pkg::ST_W-1:0]      status_ff;
   logic                           rsp_valid_ff;
   logic [DW-1:0]                  out_top_ff;
   logic [CountW-1:0]              out_depth_ff;
   logic [smie_pkg::ST_W-1:0]      out_status_ff;

   logic [DW-1:0]                  stack_mem [STACK_DEPTH];

   smie_pkg::ctrl_type ctrl;
   logic               req_fire, out_busy, taken, stack_full;
   logic [AddrW-1:0]   rd_addr, wr_addr;
   logic [CountW-1:0]  rd_index;
   logic [DW-1:0]      wr_data, alu_res;
   logic [DW:0]        rem_sh, diff;

   assign ctrl       = smie_pkg::ucode(upc_ff);
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign out_busy   = rsp_valid_ff && !rsp_ch.ready;
   assign stack_full = (count_ff == CountW'(STACK_DEPTH));

   assign req_ch.ready     = (upc_ff == smie_pkg::S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.top_value = out_top_ff;
   assign rsp_ch.depth     = out_depth_ff;
   assign rsp_ch.status    = out_status_ff;

   // Jump condition evaluation
   always_comb begin
      case (ctrl.jmp)
         smie_pkg::J_ALWAYS:  taken = 1'b1;
         smie_pkg::J_FULL:    taken = stack_full;
         smie_pkg::J_EMPTY:   taken = (count_ff == '0);
         smie_pkg::J_ONE:     taken = (count_ff == CountW'(1));
         smie_pkg::J_IS_DIV:  taken = (op_ff == smie_pkg::OP_DIV);
         smie_pkg::J_RZERO:   taken = (right_ff == '0);
         smie_pkg::J_DIVLOOP: taken = (div_cnt_ff != '0);
         default:             taken = 1'b0;
      endcase
   end

   // Next step
   always_comb begin
      if (ctrl.jmp == smie_pkg::J_WAIT_ITEM) begin
         upc_in = req_fire ? smie_pkg::entry_step(req_ch.op) : upc_ff;
      end else if (ctrl.emit && out_busy) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // Stack count update
   always_comb begin
      case (ctrl.cnt_op)
         smie_pkg::CNT_INC:   count_in = count_ff + CountW'(1);
         smie_pkg::CNT_DEC:   count_in = count_ff - CountW'(1);
         smie_pkg::CNT_DEC2:  count_in = count_ff - CountW'(2);
         smie_pkg::CNT_CLEAR: count_in = '0;
         default:             count_in = count_ff;
      endcase
   end

   // Stack addressing
   always_comb begin
      rd_index = (ctrl.rd_sel == smie_pkg::RD_NEXT) ? (count_ff - CountW'(2))
                                                    : (count_ff - CountW'(1));
      rd_addr  = rd_index[AddrW-1:0];
      wr_addr  = count_ff[AddrW-1:0];
      wr_data  = (ctrl.wr_sel == smie_pkg::WR_RES) ? res_ff : imm_ff;
   end

   // Add, subtract, multiply (low word)
   always_comb begin
      case (op_ff)
         smie_pkg::OP_ADD: alu_res = left_ff + right_ff;
         smie_pkg::OP_SUB: alu_res = left_ff - right_ff;
         smie_pkg::OP_MUL: alu_res = left_ff * right_ff;
         default:          alu_res = '0;
      endcase
   end

   // Restoring divider step on magnitudes
   assign rem_sh = {rem_ff, quo_ff[DW-1]};
   assign diff   = rem_sh - {1'b0, dvsr_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= smie_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= smie_pkg::ST_OK;
      end else begin
         upc_ff   <= upc_in;
         count_ff <= count_in;
         if (req_fire) begin
            status_ff <= smie_pkg::ST_OK;
         end else if (ctrl.st_load) begin
            status_ff <= ctrl.st_value;
         end
         if (ctrl.emit && !out_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Stack memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_sel != smie_pkg::RD_NONE) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_ch.op;
         imm_ff <= req_ch.immediate;
      end
      if (ctrl.ld_right) right_ff <= rd_data_ff;
      if (ctrl.ld_left)  left_ff  <= rd_data_ff;
      case (ctrl.res_sel)
         smie_pkg::RES_ALU:  res_ff <= alu_res;
         smie_pkg::RES_QUOT: res_ff <= neg_q_ff ? (DW'(0) - quo_ff) : quo_ff;
         default:            res_ff <= res_ff;
      endcase
      if (ctrl.div_init) begin
         quo_ff     <= left_ff[DW-1] ? (DW'(0) - left_ff) : left_ff;
         dvsr_ff    <= right_ff[DW-1] ? (DW'(0) - right_ff) : right_ff;
         rem_ff     <= '0;
         neg_q_ff   <= left_ff[DW-1] ^ right_ff[DW-1];
         div_cnt_ff <= smie_pkg::DIV_CNT_W'(DW - 1);
      end else if (ctrl.div_step) begin
         if (!diff[DW]) begin
            rem_ff <= diff[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
      // Result register
      if (ctrl.emit && !out_busy) begin
         out_top_ff    <= (count_ff == '0) ? '0 : rd_data_ff;
         out_depth_ff  <= count_ff;
         out_status_ff <= status_ff;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == smie_pkg::S_FIN1 && out_busy) |=> rsp_valid_ff && upc_ff == smie_pkg::S_FIN1)
      else $error("pending result overwritten");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == smie_pkg::S_DIV2) |-> (dvsr_ff != '0))
      else $error("divider running with zero divisor");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (upc_ff != smie_pkg::S_IDLE))
      else $error("accepted item not started");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for stack_machine_int_exec: drives instruction items,
// predicts each result from a model of the stack, and checks every result item.
// Depends on smie_pkg, smie_if and the stack_machine_int_exec RTL.

module tb;
   import smie_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int COUNT_W      = 5;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 60;

   // Op codes the block does not use; they must leave the stack alone
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic signed [DATA_W-1:0] top_value;
      logic [COUNT_W-1:0]       depth;
      logic [ST_W-1:0]          status;
   } stack_result_type;

   // Stack model, queue of expected result items and their checking
   class stack_checker_type;
      bit [DATA_W-1:0]  store [STACK_DEPTH];
      int unsigned      count;
      stack_result_type expected_results[$];
      int               errors;
      int               accepted;
      int               checked;
      int               status_seen[4];

      function new();
         count    = 0;
         errors   = 0;
         accepted = 0;
         checked  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Apply one instruction to the stack and return the result item
      function stack_result_type exec_instr(logic [OP_W-1:0] op, logic [DATA_W-1:0] imm);
         stack_result_type  r;
         logic [DATA_W-1:0] left, right, res, mag_l, mag_r, quo;
         bit                push_res;
         r.status = ST_OK;
         case (op)
            OP_PUSH: begin
               if (count >= STACK_DEPTH) begin
                  r.status = ST_OVERFLOW;
               end else begin
                  store[count] = imm;
                  count++;
               end
            end
            OP_POP: begin
               if (count == 0) r.status = ST_UNDERFLOW;
               else count--;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (count == 0) begin
                  r.status = ST_UNDERFLOW;
               end else if (count == 1) begin
                  // lone operand is consumed
                  count    = 0;
                  r.status = ST_UNDERFLOW;
               end else begin
                  right    = store[count-1];
                  left     = store[count-2];
                  count    -= 2;
                  push_res = 1'b1;
                  res      = '0;
                  case (op)
                     OP_ADD: res = left + right;
                     OP_SUB: res = left - right;
                     OP_MUL: res = left * right;
                     default: begin
                        if (right == '0) begin
                           r.status = ST_DIVZERO;
                           push_res = 1'b0;
                        end else begin
                           // truncating signed divide on magnitudes
                           mag_l = left[DATA_W-1]  ? -left  : left;
                           mag_r = right[DATA_W-1] ? -right : right;
                           quo   = mag_l / mag_r;
                           res   = (left[DATA_W-1] ^ right[DATA_W-1]) ? -quo : quo;
                        end
                     end
                  endcase
                  if (push_res) begin
                     store[count] = res;
                     count++;
                  end
               end
            end
            default: ;
         endcase
         r.top_value = (count == 0) ? '0 : store[count-1];
         r.depth     = COUNT_W'(count);
         return r;
      endfunction

      function void note_instr(logic [OP_W-1:0] op, logic [DATA_W-1:0] imm);
         expected_results.push_back(exec_instr(op, imm));
         accepted++;
      endfunction

      function void check_result(logic signed [DATA_W-1:0] top_value,
                                 logic [COUNT_W-1:0] depth, logic [ST_W-1:0] status);
         stack_result_type e;
         if (expected_results.size() == 0) begin
            $error("unexpected result item: top_value %0d depth %0d status %0d",
                   top_value, depth, status);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         checked++;
         status_seen[e.status]++;
         if (top_value !== e.top_value) begin
            $error("top_value mismatch: expected %0d, actual %0d", e.top_value, top_value);
            errors++;
         end
         if (depth !== e.depth) begin
            $error("depth mismatch: expected %0d, actual %0d", e.depth, depth);
            errors++;
         end
         if (status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   smie_req_if                    req_ch();
   smie_rsp_if #(.COUNT_W(COUNT_W)) rsp_ch();

   stack_machine_int_exec #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   stack_checker_type board = new();   // checks what the block returns
   stack_checker_type plan  = new();   // tracks the stack as the stimulus is chosen
   bit                hold_req  = 1'b0;
   bit                fill_mode = 1'b1;
   int                idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Accepted items on both channels
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_instr(req_ch.op, req_ch.immediate);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.top_value, rsp_ch.depth, rsp_ch.status);
   end

   // Watchdog: too long without any item moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("stack_machine_int_exec regression: fail");
         $finish;
      end
   end

   // Receiver: segments of steady, random or sparse ready, plus one long hold-off
   initial begin : receiver
      int seg_len;
      int seg_mode;
      rsp_ch.ready <= 1'b0;
      forever begin
         seg_len  = $urandom_range(20, 200);
         seg_mode = $urandom_range(0, 2);
         for (int i = 0; i < seg_len; i++) begin
            if (hold_req) begin
               rsp_ch.ready <= 1'b0;
               for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clock);
               hold_req = 1'b0;
            end
            case (seg_mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= $urandom_range(0, 1);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one item and wait for it to be taken; valid stays high afterwards
   task automatic send_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm);
      void'(plan.exec_instr(op, imm));
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.immediate <= imm;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0;
         3:       return 32'hffff_ffff;
         4, 5:    return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   // Fill towards a full stack, then drain towards empty, with some noise
   function automatic logic [OP_W-1:0] pick_op();
      int unsigned roll;
      if (plan.count == 0)
         fill_mode = 1'b1;
      else if (plan.count == STACK_DEPTH && $urandom_range(0, 99) >= 30)
         fill_mode = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll == 0) return OP_SPARE6;
      if (roll == 1) return OP_SPARE7;
      if (roll < 6)  return OP_W'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < (fill_mode ? 70 : 25)) return OP_PUSH;
      case ($urandom_range(0, 4))
         0:       return OP_POP;
         1:       return OP_ADD;
         2:       return OP_SUB;
         3:       return OP_MUL;
         default: return OP_DIV;
      endcase
   endfunction

   initial begin : stimulus
      int               real_sent;
      int               burst;
      int               gap;
      bit               did_hold;
      bit               did_drain;
      logic [OP_W-1:0]  op;
      real_sent = 0;
      did_hold  = 1'b0;
      did_drain = 1'b0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= OP_PUSH;
      req_ch.immediate <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-stack cases, wrap-around, odd divisions, lone operand
      send_instr(OP_POP,    32'hffff_ffff);
      send_instr(OP_ADD,    32'h0);
      send_instr(OP_SPARE6, 32'h1234_5678);
      send_instr(OP_PUSH,   32'h7fff_ffff);
      send_instr(OP_PUSH,   32'h1);
      send_instr(OP_ADD,    32'hffff_ffff);
      send_instr(OP_PUSH,   32'hffff_ffff);
      send_instr(OP_DIV,    32'h0);              // most negative by minus one
      send_instr(OP_PUSH,   32'h0);
      send_instr(OP_DIV,    32'h0);              // divide by zero, both consumed
      send_instr(OP_PUSH,   32'h5);
      send_instr(OP_SUB,    32'h0);              // single entry consumed
      send_instr(OP_PUSH,   32'h7);
      send_instr(OP_PUSH,   32'hffff_fffe);
      send_instr(OP_MUL,    32'h0);
      send_instr(OP_PUSH,   32'hffff_fffd);
      send_instr(OP_SUB,    32'h0);
      send_instr(OP_PUSH,   32'h4);
      send_instr(OP_DIV,    32'h0);              // truncates toward zero
      send_instr(OP_PUSH,   32'h8000_0000);
      send_instr(OP_MUL,    32'h0);
      send_instr(OP_SPARE7, 32'hffff_ffff);
      send_instr(OP_POP,    32'h0);
      send_instr(OP_POP,    32'h0);
      send_instr(OP_MUL,    32'h0);
      drain_results();

      // Random bursts with random gaps
      while (real_sent < RANDOM_ITEMS) begin
         if (!did_hold && real_sent >= 600) begin
            hold_req = 1'b1;
            did_hold = 1'b1;
         end
         if (!did_drain && real_sent >= 1200) begin
            drain_results();
            did_drain = 1'b1;
         end
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst; k++) begin
            op = pick_op();
            send_instr(op, (op == OP_PUSH) ? pick_value() : $urandom());
            if (op <= OP_DIV) real_sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         $error("%0d expected result items never arrived", board.pending());
         board.errors++;
      end
      $display("summary: %0d instructions accepted, %0d result items checked",
               board.accepted, board.checked);
      $display("statuses: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
               board.status_seen[ST_OK], board.status_seen[ST_UNDERFLOW],
               board.status_seen[ST_OVERFLOW], board.status_seen[ST_DIVZERO]);
      if (board.errors == 0)
         $display("stack_machine_int_exec regression: pass");
      else
         $display("stack_machine_int_exec regression: fail");
      $finish;
   end

endmodule

// File: sim.f
src/smie_pkg.sv
src/smie_if.sv
src/stack_machine_int_exec.sv
tb/sv/tb.sv
